[src/dnsqeab_pkg.sv]
// ----------------------------------------------------------------------------
// dnsqeab_pkg
// shared constants and the queue entry type of the dns answer builder
// ----------------------------------------------------------------------------
package dnsqeab_pkg;

  localparam int MaxQueryBytes = 512;
  localparam int CountWidth    = $clog2(MaxQueryBytes + 1);

  localparam int QueueDepth    = 4;
  localparam int QueuePtrWidth = $clog2(QueueDepth);
  localparam int QueueCntWidth = $clog2(QueueDepth + 1);

  localparam logic [15:0] QtypeA    = 16'h0001;
  localparam logic [15:0] QtypeAaaa = 16'h001C;

  localparam logic [15:0] ResetReplyFlags = 16'h8180;
  localparam logic [31:0] ResetAnswerTtl  = 32'd30;

  localparam logic CfgReplyFlags = 1'b0;
  localparam logic CfgAnswerTtl  = 1'b1;

  // answer record kinds
  localparam logic [2:0] RecNone   = 3'd0;
  localparam logic [2:0] RecLen0   = 3'd1;
  localparam logic [2:0] RecA      = 3'd2;
  localparam logic [2:0] RecMapped = 3'd3;
  localparam logic [2:0] RecV6     = 3'd4;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        error;
    logic [2:0]  kind;
    logic [15:0] qtype;
    logic [7:0]  class_hi;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } entry_t;

endpackage

[src/dns_query_echo_answer_builder_unit.sv]
// ----------------------------------------------------------------------------
// dns_query_echo_answer_builder_unit
// turns a dns query byte stream into an answer holding the client address
// ----------------------------------------------------------------------------
// path: a reply byte passes through the queue and then the output register
// throughput: one query byte and one reply byte per cycle, while neither side
//   stalls; the answer record adds up to 28 reply bytes, emitted one a cycle
//   while out_stall is low, and input stalls once the four-entry queue
//   between parser and emitter is full
// reset: parse state and queue cleared, reply flags 0x8180, ttl 30
module dns_query_echo_answer_builder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  query_byte,
  input  logic        query_last,
  input  logic        client_is_v6,
  input  logic [63:0] client_addr_hi,
  input  logic [63:0] client_addr_lo,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  reply_byte,
  output logic        reply_last,
  output logic        reply_error
);

  logic [15:0]         reply_flags;
  logic [31:0]         answer_ttl;
  logic                push;
  dnsqeab_pkg::entry_t push_entry;
  logic                queue_full;
  logic                head_valid;
  dnsqeab_pkg::entry_t head_entry;
  logic                pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_flags <= dnsqeab_pkg::ResetReplyFlags;
      answer_ttl  <= dnsqeab_pkg::ResetAnswerTtl;
    end else if (cfg_write) begin
      case (cfg_index)
        dnsqeab_pkg::CfgReplyFlags: reply_flags <= cfg_data[15:0];
        dnsqeab_pkg::CfgAnswerTtl:  answer_ttl  <= cfg_data;
        default:                    answer_ttl  <= answer_ttl;
      endcase
    end
  end

  dnsqeab_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .query_byte     (query_byte),
    .query_last     (query_last),
    .client_is_v6   (client_is_v6),
    .client_addr_hi (client_addr_hi),
    .client_addr_lo (client_addr_lo),
    .reply_flags    (reply_flags),
    .queue_full     (queue_full),
    .push           (push),
    .push_entry     (push_entry)
  );

  dnsqeab_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  dnsqeab_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .pop         (pop),
    .answer_ttl  (answer_ttl),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .reply_byte  (reply_byte),
    .reply_last  (reply_last),
    .reply_error (reply_error)
  );

endmodule

[src/dnsqeab_queue.sv]
// ----------------------------------------------------------------------------
// dnsqeab_queue
// small register queue between the parser and the reply emitter
// ----------------------------------------------------------------------------
module dnsqeab_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dnsqeab_pkg::entry_t   push_entry,
  output logic                  full,
  output logic                  head_valid,
  output dnsqeab_pkg::entry_t   head_entry,
  input  logic                  pop
);

  dnsqeab_pkg::entry_t slots [dnsqeab_pkg::QueueDepth];
  logic [dnsqeab_pkg::QueuePtrWidth-1:0] wr_ptr;
  logic [dnsqeab_pkg::QueuePtrWidth-1:0] rd_ptr;
  logic [dnsqeab_pkg::QueueCntWidth-1:0] count;

  assign full       = (count == dnsqeab_pkg::QueueCntWidth'(dnsqeab_pkg::QueueDepth));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/dnsqeab_front.sv]
// ----------------------------------------------------------------------------
// dnsqeab_front
// query parser: walks header, labels, type and class and queues reply words
// ----------------------------------------------------------------------------
module dnsqeab_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            query_byte,
  input  logic                  query_last,
  input  logic                  client_is_v6,
  input  logic [63:0]           client_addr_hi,
  input  logic [63:0]           client_addr_lo,
  input  logic [15:0]           reply_flags,
  input  logic                  queue_full,
  output logic                  push,
  output dnsqeab_pkg::entry_t   push_entry
);

  localparam logic [2:0] PhHeader  = 3'd0;
  localparam logic [2:0] PhLen     = 3'd1;
  localparam logic [2:0] PhBody    = 3'd2;
  localparam logic [2:0] PhTypeHi  = 3'd3;
  localparam logic [2:0] PhTypeLo  = 3'd4;
  localparam logic [2:0] PhClassHi = 3'd5;
  localparam logic [2:0] PhClassLo = 3'd6;
  localparam logic [2:0] PhDrop    = 3'd7;

  localparam logic [3:0] HdrFlagsHi = 4'd2;
  localparam logic [3:0] HdrFlagsLo = 4'd3;
  localparam logic [3:0] HdrAnCntHi = 4'd6;
  localparam logic [3:0] HdrAnCntLo = 4'd7;
  localparam logic [3:0] HdrLength  = 4'd12;

  logic [2:0]  phase, phase_next;
  logic [3:0]  hdr_pos, hdr_pos_next;
  logic [7:0]  label_left, label_left_next;
  logic [15:0] qtype, qtype_next;
  logic [7:0]  class_hi, class_hi_next;
  logic [dnsqeab_pkg::CountWidth-1:0] count, count_next;
  logic        accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  always_comb begin
    phase_next      = phase;
    hdr_pos_next    = hdr_pos;
    label_left_next = label_left;
    qtype_next      = qtype;
    class_hi_next   = class_hi;
    count_next      = count;
    push            = 1'b0;
    push_entry.data     = query_byte;
    push_entry.last     = 1'b0;
    push_entry.error    = 1'b0;
    push_entry.kind     = dnsqeab_pkg::RecNone;
    push_entry.qtype    = qtype;
    push_entry.class_hi = class_hi;
    push_entry.addr_hi  = client_addr_hi;
    push_entry.addr_lo  = client_addr_lo;

    if (accept) begin
      if (phase == PhDrop) begin
        if (query_last) begin
          phase_next = PhHeader;
        end
      end else if ((count >= dnsqeab_pkg::CountWidth'(dnsqeab_pkg::MaxQueryBytes)) ||
                   (query_last && (phase != PhClassLo))) begin
        push             = 1'b1;
        push_entry.data  = 8'h00;
        push_entry.last  = 1'b1;
        push_entry.error = 1'b1;
        phase_next       = query_last ? PhHeader : PhDrop;
      end else begin
        push       = 1'b1;
        count_next = count + 1'b1;
        case (phase)
          PhHeader: begin
            case (hdr_pos)
              HdrFlagsHi: push_entry.data = reply_flags[15:8];
              HdrFlagsLo: push_entry.data = reply_flags[7:0];
              HdrAnCntHi: push_entry.data = 8'h00;
              HdrAnCntLo: push_entry.data = 8'h01;
              default:    push_entry.data = query_byte;
            endcase
            hdr_pos_next = hdr_pos + 1'b1;
            if (hdr_pos_next >= HdrLength) begin
              phase_next = PhLen;
            end
          end
          PhLen: begin
            if (query_byte == 8'h00) begin
              phase_next = PhTypeHi;
            end else begin
              label_left_next = query_byte;
              phase_next      = PhBody;
            end
          end
          PhBody: begin
            label_left_next = label_left - 1'b1;
            if (label_left_next == 8'h00) begin
              phase_next = PhLen;
            end
          end
          PhTypeHi: begin
            qtype_next = {query_byte, 8'h00};
            phase_next = PhTypeLo;
          end
          PhTypeLo: begin
            qtype_next = {qtype[15:8], query_byte};
            phase_next = PhClassHi;
          end
          PhClassHi: begin
            class_hi_next = query_byte;
            phase_next    = PhClassLo;
          end
          default: begin
            if (!client_is_v6) begin
              if (qtype == dnsqeab_pkg::QtypeA) begin
                push_entry.kind = dnsqeab_pkg::RecA;
              end else if (qtype == dnsqeab_pkg::QtypeAaaa) begin
                push_entry.kind = dnsqeab_pkg::RecMapped;
              end else begin
                push_entry.kind = dnsqeab_pkg::RecLen0;
              end
            end else if (qtype == dnsqeab_pkg::QtypeAaaa) begin
              push_entry.kind = dnsqeab_pkg::RecV6;
            end else begin
              push_entry.kind = dnsqeab_pkg::RecNone;
            end
            push_entry.last = (push_entry.kind == dnsqeab_pkg::RecNone);
            phase_next      = query_last ? PhHeader : PhDrop;
          end
        endcase
      end

      // packet end clears the parse state
      if (query_last && (phase_next == PhHeader)) begin
        hdr_pos_next    = '0;
        label_left_next = '0;
        qtype_next      = '0;
        class_hi_next   = '0;
        count_next      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PhHeader;
      hdr_pos    <= '0;
      label_left <= '0;
      qtype      <= '0;
      class_hi   <= '0;
      count      <= '0;
    end else begin
      phase      <= phase_next;
      hdr_pos    <= hdr_pos_next;
      label_left <= label_left_next;
      qtype      <= qtype_next;
      class_hi   <= class_hi_next;
      count      <= count_next;
    end
  end

endmodule

[src/dnsqeab_back.sv]
// ----------------------------------------------------------------------------
// dnsqeab_back
// reply emitter: drains the queue and expands the appended answer record
// ----------------------------------------------------------------------------
module dnsqeab_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  dnsqeab_pkg::entry_t   head_entry,
  output logic                  pop,
  input  logic [31:0]           answer_ttl,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            reply_byte,
  output logic                  reply_last,
  output logic                  reply_error
);

  logic [4:0]   pos;
  logic [4:0]   rec_idx;
  logic [4:0]   rec_end;
  logic [3:0]   data_idx;
  logic [15:0]  dlen;
  logic [127:0] data_word;
  logic [127:0] data_shift;
  logic         advance;
  logic         done;
  logic [7:0]   byte_sel;

  assign advance  = !out_valid || !out_stall;
  assign rec_idx  = pos - 5'd1;
  assign data_idx = 4'(rec_idx - 5'd12);

  always_comb begin
    case (head_entry.kind)
      dnsqeab_pkg::RecA: begin
        dlen      = 16'd4;
        rec_end   = 5'd15;
        data_word = {head_entry.addr_lo[31:0], 96'h0};
      end
      dnsqeab_pkg::RecMapped: begin
        dlen      = 16'd16;
        rec_end   = 5'd27;
        data_word = {80'h0, 16'hFFFF, head_entry.addr_lo[31:0]};
      end
      dnsqeab_pkg::RecV6: begin
        dlen      = 16'd16;
        rec_end   = 5'd27;
        data_word = {head_entry.addr_hi, head_entry.addr_lo};
      end
      default: begin
        dlen      = 16'd0;
        rec_end   = 5'd11;
        data_word = '0;
      end
    endcase
  end

  assign data_shift = data_word << {data_idx, 3'b000};

  always_comb begin
    case (rec_idx)
      5'd0:    byte_sel = 8'hC0;
      5'd1:    byte_sel = 8'h0C;
      5'd2:    byte_sel = head_entry.qtype[15:8];
      5'd3:    byte_sel = head_entry.qtype[7:0];
      5'd4:    byte_sel = head_entry.class_hi;
      5'd5:    byte_sel = head_entry.data;
      5'd6:    byte_sel = answer_ttl[31:24];
      5'd7:    byte_sel = answer_ttl[23:16];
      5'd8:    byte_sel = answer_ttl[15:8];
      5'd9:    byte_sel = answer_ttl[7:0];
      5'd10:   byte_sel = dlen[15:8];
      5'd11:   byte_sel = dlen[7:0];
      default: byte_sel = data_shift[127:120];
    endcase
  end

  assign done = (pos == 5'd0) ? (head_entry.kind == dnsqeab_pkg::RecNone)
                              : (rec_idx == rec_end);
  assign pop  = advance && head_valid && done;

  always_ff @(posedge clk) begin
    if (advance) begin
      if (pos == 5'd0) begin
        reply_byte  <= head_entry.data;
        reply_last  <= head_entry.last;
        reply_error <= head_entry.error;
      end else begin
        reply_byte  <= byte_sel;
        reply_last  <= done;
        reply_error <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        pos <= done ? 5'd0 : pos + 5'd1;
      end
    end
  end

endmodule

[sim/dns_query_echo_answer_builder_unit_tb.sv]
// ----------------------------------------------------------------------------
// dns_query_echo_answer_builder_unit_tb
// feeds dns query packets byte by byte, from hand-built corner cases to random
// well-formed, truncated and noisy queries, under several reply flag and ttl
// settings; a scoreboard predicts every reply word and checks the output
// stream word by word while the input idles and the output stalls at random
// ----------------------------------------------------------------------------
module dns_query_echo_answer_builder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    StHeader, StLen, StBody, StTypeHi, StTypeLo, StClassHi, StClassLo, StDrop
  } parse_stage_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       error;
  } reply_t;

  class reply_scoreboard;
    reply_t pending[$];
    int mismatches;
    logic [15:0] flags;
    logic [31:0] ttl;
    parse_stage_e stage;
    logic [3:0] hdr_pos;
    logic [7:0] label_left;
    logic [15:0] qtype;
    logic [7:0] class_hi;
    logic [dnsqeab_pkg::CountWidth-1:0] taken;

    function new();
      flags = dnsqeab_pkg::ResetReplyFlags;
      ttl = dnsqeab_pkg::ResetAnswerTtl;
      mismatches = 0;
      restart_packet();
    endfunction

    function void restart_packet();
      stage = StHeader;
      hdr_pos = '0;
      label_left = '0;
      qtype = '0;
      class_hi = '0;
      taken = '0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == dnsqeab_pkg::CfgReplyFlags) flags = value[15:0];
      else ttl = value;
    endfunction

    function void emit(logic [7:0] b);
      pending.push_back('{b, 1'b0, 1'b0});
    endfunction

    function void emit_bytes(logic [63:0] value, int n);
      for (int i = n - 1; i >= 0; i--) emit(value[8*i +: 8]);
    endfunction

    function void emit_record(logic [7:0] class_lo, logic [15:0] dlen);
      emit(8'hC0);
      emit(8'h0C);
      emit(qtype[15:8]);
      emit(qtype[7:0]);
      emit(class_hi);
      emit(class_lo);
      emit_bytes({32'h0, ttl}, 4);
      emit(dlen[15:8]);
      emit(dlen[7:0]);
    endfunction

    function void take_query(logic [7:0] b, logic last, logic v6,
                             logic [63:0] hi, logic [63:0] lo);
      logic [15:0] dlen;
      if (stage == StDrop) begin
        if (last) restart_packet();
        return;
      end
      if (taken >= dnsqeab_pkg::MaxQueryBytes || (last && stage != StClassLo)) begin
        pending.push_back('{8'h00, 1'b1, 1'b1});
        if (last) restart_packet();
        else stage = StDrop;
        return;
      end
      taken++;
      case (stage)
        StHeader: begin
          case (hdr_pos)
            4'd2: emit(flags[15:8]);
            4'd3: emit(flags[7:0]);
            4'd6: emit(8'h00);
            4'd7: emit(8'h01);
            default: emit(b);
          endcase
          hdr_pos = hdr_pos + 4'd1;
          if (hdr_pos >= 4'd12) stage = StLen;
        end
        StLen: begin
          emit(b);
          if (b == 8'h00) begin
            stage = StTypeHi;
          end else begin
            label_left = b;
            stage = StBody;
          end
        end
        StBody: begin
          emit(b);
          label_left = label_left - 8'd1;
          if (label_left == 8'd0) stage = StLen;
        end
        StTypeHi: begin
          emit(b);
          qtype = {b, 8'h00};
          stage = StTypeLo;
        end
        StTypeLo: begin
          emit(b);
          qtype = {qtype[15:8], b};
          stage = StClassHi;
        end
        StClassHi: begin
          emit(b);
          class_hi = b;
          stage = StClassLo;
        end
        default: begin
          emit(b);
          if (!v6) begin
            dlen = (qtype == dnsqeab_pkg::QtypeA) ? 16'd4 :
                   (qtype == dnsqeab_pkg::QtypeAaaa) ? 16'd16 : 16'd0;
            emit_record(b, dlen);
            if (dlen == 16'd16) begin
              emit_bytes(64'h0, 8);
              emit_bytes(64'h0, 2);
              emit(8'hFF);
              emit(8'hFF);
            end
            if (dlen != 16'd0) emit_bytes({32'h0, lo[31:0]}, 4);
          end else if (qtype == dnsqeab_pkg::QtypeAaaa) begin
            emit_record(b, 16'd16);
            emit_bytes(hi, 8);
            emit_bytes(lo, 8);
          end
          pending[pending.size()-1].last = 1'b1;
          if (last) restart_packet();
          else stage = StDrop;
        end
      endcase
    endfunction

    task report(string what);
      mismatches++;
      $display("reply mismatch: %s", what);
    endtask

    task check_reply(logic [7:0] b, logic last, logic err);
      reply_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %02h last %0b error %0b", b, last, err));
        return;
      end
      want = pending.pop_front();
      if (b !== want.data)
        report($sformatf("reply_byte got %02h want %02h", b, want.data));
      if (last !== want.last)
        report($sformatf("reply_last got %0b want %0b", last, want.last));
      if (err !== want.error)
        report($sformatf("reply_error got %0b want %0b", err, want.error));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  query_byte;
  logic        query_last;
  logic        client_is_v6;
  logic [63:0] client_addr_hi;
  logic [63:0] client_addr_lo;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  reply_byte;
  logic        reply_last;
  logic        reply_error;

  reply_scoreboard sb;
  logic [7:0] pkt[$];
  int burst_left;
  bit steady;
  int stall_mode = 0;
  int stall_left = 0;

  dns_query_echo_answer_builder_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .query_byte(query_byte),
    .query_last(query_last),
    .client_is_v6(client_is_v6),
    .client_addr_hi(client_addr_hi),
    .client_addr_lo(client_addr_lo),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .reply_byte(reply_byte),
    .reply_last(reply_last),
    .reply_error(reply_error)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (stall_left % 5) < 2;
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_reply(reply_byte, reply_last, reply_error);
      if (in_valid && !in_stall)
        sb.take_query(query_byte, query_last, client_is_v6, client_addr_hi, client_addr_lo);
    end
  end

  task write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task send_word(logic [7:0] b, logic last, logic v6, logic [63:0] hi, logic [63:0] lo);
    @(negedge clk);
    in_valid <= 1'b1;
    query_byte <= b;
    query_last <= last;
    client_is_v6 <= v6;
    client_addr_hi <= hi;
    client_addr_lo <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!steady) begin
      if (burst_left == 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task wait_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // the last query word may still be in flight with nothing to show for it
  task settle();
    wait_replies();
    repeat (10) @(negedge clk);
  endtask

  function void add_header(int fill);
    for (int i = 0; i < 12; i++) pkt.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
  endfunction

  function void add_label(int len, int fill);
    pkt.push_back(8'(len));
    for (int i = 0; i < len; i++) pkt.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
  endfunction

  function void add_question(logic [15:0] qt, logic [15:0] qc);
    pkt.push_back(8'h00);
    pkt.push_back(qt[15:8]);
    pkt.push_back(qt[7:0]);
    pkt.push_back(qc[15:8]);
    pkt.push_back(qc[7:0]);
  endfunction

  function void add_noise(int n);
    for (int i = 0; i < n; i++) pkt.push_back(8'($urandom));
  endfunction

  task send_packet(logic v6, logic [63:0] hi, logic [63:0] lo);
    for (int i = 0; i < pkt.size(); i++) send_word(pkt[i], i == pkt.size() - 1, v6, hi, lo);
    pkt.delete();
  endtask

  task random_packet();
    int kind;
    int nlab;
    int cut;
    logic [15:0] qt;
    logic v6;
    logic [63:0] hi;
    logic [63:0] lo;
    kind = $urandom_range(0, 9);
    v6 = $urandom_range(0, 1);
    hi = {$urandom, $urandom};
    lo = {$urandom, $urandom};
    steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) wait_replies();
    if (kind == 9) begin
      add_noise($urandom_range(1, 8));
    end else begin
      add_header(-1);
      nlab = $urandom_range(0, 1);
      repeat (nlab) add_label($urandom_range(1, 3), -1);
      case ($urandom_range(0, 3))
        0: qt = dnsqeab_pkg::QtypeA;
        1: qt = dnsqeab_pkg::QtypeAaaa;
        2: qt = 16'($urandom);
        default: qt = {8'h00, 8'($urandom)};
      endcase
      add_question(qt, 16'($urandom));
      if (kind >= 7) begin
        // end the query somewhere before the last class byte
        cut = $urandom_range(1, pkt.size() - 1);
        repeat (cut) void'(pkt.pop_back());
      end else begin
        add_noise($urandom_range(0, 2));
      end
    end
    send_packet(v6, hi, lo);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = dnsqeab_pkg::CfgReplyFlags;
    cfg_data = '0;
    in_valid = 1'b0;
    query_byte = '0;
    query_last = 1'b0;
    client_is_v6 = 1'b0;
    client_addr_hi = '0;
    client_addr_lo = '0;
    steady = 1'b1;
    burst_left = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // reset register values
    add_header(8'hFF);
    add_question(dnsqeab_pkg::QtypeA, 16'h0001);
    send_packet(1'b0, '1, '1);
    add_header(8'h00);
    add_question(dnsqeab_pkg::QtypeAaaa, 16'hFFFF);
    add_noise(2);
    send_packet(1'b0, '0, 64'h0000_0000_C0A8_0001);
    steady = 1'b0;
    add_header(-1);
    add_label(2, -1);
    add_question(dnsqeab_pkg::QtypeAaaa, 16'h0001);
    send_packet(1'b1, 64'h2001_0DB8_0000_0001, '1);
    add_header(-1);
    add_question(dnsqeab_pkg::QtypeA, 16'h0001);
    add_noise(1);
    send_packet(1'b1, {$urandom, $urandom}, {$urandom, $urandom});
    add_header(-1);
    add_question(16'h001D, 16'h0001);
    send_packet(1'b0, '1, '1);
    pkt.push_back(8'h12);
    send_packet(1'b0, '0, '0);
    // early end on a label length byte
    add_header(-1);
    add_label(3, -1);
    repeat (3) void'(pkt.pop_back());
    send_packet(1'b0, '0, '0);

    settle();
    write_reg(dnsqeab_pkg::CfgReplyFlags, 32'h0000_0000);
    write_reg(dnsqeab_pkg::CfgAnswerTtl, 32'hFFFF_FFFF);
    random_packet();
    settle();
    write_reg(dnsqeab_pkg::CfgReplyFlags, {16'h0, 16'($urandom)});
    write_reg(dnsqeab_pkg::CfgAnswerTtl, $urandom);
    random_packet();
    settle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
